[src/rht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Table geometry, slot layout and status codes shared by the table logic.
// ----------------------------------------------------------------------------
package rht_pkg;

   // The slot count must be a power of two: the home slot is the low hash bits.
   localparam int TABLE_SLOTS = 1024;
   localparam int PROBE_LIMIT = 128;
   localparam int IDX_W       = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
   localparam int LOAD_LIMIT  = TABLE_SLOTS - (TABLE_SLOTS + 8) / 10;
   localparam int DIST_W      = 7;
   localparam int TAG_W       = 7;
   localparam int K_W         = 8;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 64;

   localparam logic OP_FIND   = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_REFUSED   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   typedef struct packed {
      logic [DIST_W-1:0] probe_dist;
      logic              occ;
      logic [TAG_W-1:0]  tag;
   } meta_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [KEY_W-1:0] key;
      meta_type         meta;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage
`default_nettype wire

[src/robin_hood_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Finds and inserts 32-bit keys with 64-bit values in a slot memory.
// ----------------------------------------------------------------------------
// Usage: a request transaction carries the operation in req_tuser (0 find,
// 1 insert) and key and value in req_tdata. Every request gives exactly one
// response transaction: the status in rsp_tuser and the found value in
// rsp_tdata (zero unless the status is found).
// Timing: an insert refused at the load limit answers in the cycle after the
// request. Otherwise the home slot is read in the accept cycle and the slot
// memory returns one slot per cycle; a swap write goes out while the next
// slot is read. A new request can be taken only in the idle state, when the
// response register is empty or is being emptied.
// Reset: the slot memory is swept clear after reset, one slot per cycle, over
// all TABLE_SLOTS (1024) slots; no request is accepted during that sweep.
// Stalls: a response waits in its register while rsp_tready is low, and no
// further request is accepted until it has been taken.
// ----------------------------------------------------------------------------
module robin_hood_hash_table import rht_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,  // key [31:0], value [95:32]
   input  wire logic         req_tuser,  // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [63:0]  rsp_tdata,  // found_value [63:0]
   output logic      [2:0]   rsp_tuser   // status [2:0]
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             op_ff, op_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr, idx_next, home;
   slot_type         wr_data, rd_data;
   logic [KEY_W-1:0] req_key, hash;
   logic [K_W-1:0]   k_step;
   logic             accept, refuse;

   rht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_key = req_tdata[KEY_W-1:0];
   // key * 33, kept to 32 bits
   assign hash    = (req_key << 5) + req_key;
   assign home    = hash[IDX_W-1:0];
   assign idx_next = (idx_ff == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign refuse     = (req_tuser == OP_INSERT) && (count_ff >= CNT_W'(LOAD_LIMIT));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = status_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      rsp_val_in   = rsp_val_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = idx_next;
      k_step       = k_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_next;
            if (idx_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (refuse) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_REFUSED;
                  rsp_val_in   = '0;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = home;
                  idx_in   = home;
                  k_in     = '0;
                  op_in    = req_tuser;
                  tag_in   = hash[KEY_W-1 -: TAG_W];
                  key_in   = req_key;
                  val_in   = req_tdata[KEY_W +: VAL_W];
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (op_ff == OP_FIND) begin
               if (!rd_data.meta.occ || (k_ff > {1'b0, rd_data.meta.probe_dist})) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_NOT_FOUND;
                  rsp_val_in   = '0;
                  state_in     = S_IDLE;
               end else if ((rd_data.meta.tag == tag_ff) && (rd_data.key == key_ff)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_FOUND;
                  rsp_val_in   = rd_data.value;
                  state_in     = S_IDLE;
               end else if (k_ff + 1'b1 == K_W'(PROBE_LIMIT)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_NOT_FOUND;
                  rsp_val_in   = '0;
                  state_in     = S_IDLE;
               end else begin
                  k_in   = k_ff + 1'b1;
                  idx_in = idx_next;
                  rd_en  = 1'b1;
               end
            end else begin
               wr_data.value    = val_ff;
               wr_data.key      = key_ff;
               wr_data.meta.probe_dist = k_ff[DIST_W-1:0];
               wr_data.meta.occ = 1'b1;
               wr_data.meta.tag = tag_ff;
               if (!rd_data.meta.occ) begin
                  wr_en        = 1'b1;
                  count_in     = count_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_INSERTED;
                  rsp_val_in   = '0;
                  state_in     = S_IDLE;
               end else begin
                  // A richer resident gives up its slot and is carried on.
                  if (k_ff > {1'b0, rd_data.meta.probe_dist}) begin
                     wr_en  = 1'b1;
                     k_step = {1'b0, rd_data.meta.probe_dist};
                     tag_in = rd_data.meta.tag;
                     key_in = rd_data.key;
                     val_in = rd_data.value;
                  end
                  if (k_step + 1'b1 == K_W'(PROBE_LIMIT)) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_OVERFLOW;
                     rsp_val_in   = '0;
                     state_in     = S_IDLE;
                  end else begin
                     k_in   = k_step + 1'b1;
                     idx_in = idx_next;
                     rd_en  = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      op_ff      <= op_in;
      tag_ff     <= tag_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      rsp_val_ff <= rsp_val_in;
   end

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("request taken outside the idle state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LOAD_LIMIT))
      else $error("entry count passed the load limit");

   a_work_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == S_EVAL) || rsp_valid_ff))
      else $error("accepted request neither probing nor answered");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot written and read at the same address");
`endif

endmodule
`default_nettype wire

[src/rht_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire
